// ===== design/rso_pkg.sv =====
package rso_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int RADIUS_WIDTH    = 15;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(256);

endpackage

// ===== design/rso_in_if.sv =====
interface rso_in_if #(
    parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] eye_x;
    logic signed [COORD_WIDTH-1:0] eye_y;
    logic signed [COORD_WIDTH-1:0] eye_z;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] centre_x;
    logic signed [COORD_WIDTH-1:0] centre_y;
    logic signed [COORD_WIDTH-1:0] centre_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    centre_x, centre_y, centre_z, input ready);
    modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  centre_x, centre_y, centre_z, output ready);
endinterface

// ===== design/rso_out_if.sv =====
interface rso_out_if;
    logic valid;
    logic ready;
    logic ray_hits;
    logic occludes;

    modport source (output valid, ray_hits, occludes, input ready);
    modport sink (input valid, ray_hits, occludes, output ready);
endinterface

// ===== design/ray_sphere_occlusion_test.sv =====
// Ray / sphere occlusion test.
// Request channel i_in carries eye, target and sphere centre (signed Q7.8);
// result channel o_out carries ray_hits and occludes, one result per request.
// Both channels use valid/ready; a request is taken when both are high.
// i_cfg_we/i_cfg_wdata load the sphere radius (unsigned Q7.8); write it only
// while the pipe is empty.
// Throughput: one request per cycle unless the output stalls; the eight stage pipeline (differences,
// products, dot sums, offsets, split partial products, wide products,
// discriminant, compares) holds up to eight requests in flight.
// Each stage has its own valid bit and advances when it is empty or the next
// one moves, so bubbles close up while the output is stalled; a full pipe
// with a stalled receiver holds every stage and drops ready.
// Reset (synchronous, active low) clears all valid bits and sets the radius
// to 1.0.
module ray_sphere_occlusion_test #(
    parameter int COORD_WIDTH = rso_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rso_pkg::RADIUS_WIDTH-1:0]  i_cfg_wdata,
    rso_in_if.sink                            i_in,
    rso_out_if.source                         o_out
);
    import rso_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SW   = 2 * DW;
    localparam int RSQ  = 2 * RADIUS_WIDTH;
    localparam int PW   = ((SW > RSQ) ? SW : RSQ) + 3;
    localparam int MW   = PW + 1;
    localparam int H    = MW / 2;
    localparam int HW   = MW - H;
    localparam int PPW  = 2 * MW;
    localparam int DDW  = PPW + 1;
    localparam int NST  = 8;

    logic [RADIUS_WIDTH-1:0] r_radius;
    logic [NST:1]            r_v;
    logic [NST+1:1]          en;

    always_comb begin
        en[NST+1] = o_out.ready;
        for (int k = NST; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_in.valid;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: w = target - eye, v = centre - eye
    logic signed [DW-1:0] r_w [3];
    logic signed [DW-1:0] r_c [3];
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_w[0] <= DW'(i_in.target_x) - DW'(i_in.eye_x);
            r_w[1] <= DW'(i_in.target_y) - DW'(i_in.eye_y);
            r_w[2] <= DW'(i_in.target_z) - DW'(i_in.eye_z);
            r_c[0] <= DW'(i_in.centre_x) - DW'(i_in.eye_x);
            r_c[1] <= DW'(i_in.centre_y) - DW'(i_in.eye_y);
            r_c[2] <= DW'(i_in.centre_z) - DW'(i_in.eye_z);
        end
    end

    // stage 2: element products and r^2
    logic signed [SW-1:0]  r_ww [3];
    logic signed [SW-1:0]  r_cw [3];
    logic signed [SW-1:0]  r_cc [3];
    logic        [RSQ-1:0] r_rr;
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_ww[i] <= r_w[i] * r_w[i];
                r_cw[i] <= r_c[i] * r_w[i];
                r_cc[i] <= r_c[i] * r_c[i];
            end
            r_rr <= r_radius * r_radius;
        end
    end

    // stage 3: L2, p, q
    logic signed [PW-1:0] r_l2, r_p, r_q;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_l2 <= PW'(r_ww[0]) + PW'(r_ww[1]) + PW'(r_ww[2]);
            r_p  <= PW'(r_cw[0]) + PW'(r_cw[1]) + PW'(r_cw[2]);
            r_q  <= PW'(r_cc[0]) + PW'(r_cc[1]) + PW'(r_cc[2]) - $signed(PW'(r_rr));
        end
    end

    // stage 4: a = L2 - p, b = -L2 - p
    logic signed [MW-1:0] r_l2m, r_pm, r_qm, r_a, r_b;
    logic                 r_nz4;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_l2m <= MW'(r_l2);
            r_pm  <= MW'(r_p);
            r_qm  <= MW'(r_q);
            r_a   <= MW'(r_l2) - MW'(r_p);
            r_b   <= -MW'(r_l2) - MW'(r_p);
            r_nz4 <= (r_l2 != '0);
        end
    end

    // stage 5: split p*p, q*L2, a*a, b*b into half-width partial products
    logic signed [MW-1:0]     opx [4];
    logic signed [MW-1:0]     opy [4];
    logic signed [2*HW-1:0]   r_hh [4];
    logic signed [HW+H:0]     r_hl [4];
    logic signed [HW+H:0]     r_lh [4];
    logic        [2*H-1:0]    r_ll [4];
    logic                     r_nz5, r_apos5, r_bneg5;
    always_comb begin
        opx[0] = r_pm;  opy[0] = r_pm;
        opx[1] = r_qm;  opy[1] = r_l2m;
        opx[2] = r_a;   opy[2] = r_a;
        opx[3] = r_b;   opy[3] = r_b;
    end
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 4; k++) begin
                r_hh[k] <= $signed(opx[k][MW-1:H]) * $signed(opy[k][MW-1:H]);
                r_hl[k] <= $signed(opx[k][MW-1:H]) * $signed({1'b0, opy[k][H-1:0]});
                r_lh[k] <= $signed({1'b0, opx[k][H-1:0]}) * $signed(opy[k][MW-1:H]);
                r_ll[k] <= opx[k][H-1:0] * opy[k][H-1:0];
            end
            r_nz5   <= r_nz4;
            r_apos5 <= (r_a > 0);
            r_bneg5 <= (r_b < 0);
        end
    end

    // stage 6: recombine into full products
    logic signed [PPW-1:0] r_prod [4];
    logic                  r_nz6, r_apos6, r_bneg6;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= (PPW'(r_hh[k]) <<< (2 * H))
                           + (PPW'(r_hl[k]) <<< H)
                           + (PPW'(r_lh[k]) <<< H)
                           + $signed(PPW'(r_ll[k]));
            end
            r_nz6   <= r_nz5;
            r_apos6 <= r_apos5;
            r_bneg6 <= r_bneg5;
        end
    end

    // stage 7: discriminant D = p^2 - q*L2
    logic signed [DDW-1:0] r_d, r_aa, r_bb;
    logic                  r_nz7, r_apos7, r_bneg7;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_d     <= DDW'(r_prod[0]) - DDW'(r_prod[1]);
            r_aa    <= DDW'(r_prod[2]);
            r_bb    <= DDW'(r_prod[3]);
            r_nz7   <= r_nz6;
            r_apos7 <= r_apos6;
            r_bneg7 <= r_bneg6;
        end
    end

    // stage 8: hit and occlusion by comparing squares
    logic n_hit, n_occ;
    logic r_hit, r_occ;
    always_comb begin
        n_hit = r_nz7 && (r_d >= 0);
        n_occ = n_hit && r_apos7 && (r_d < r_aa) && (r_bneg7 || (r_d > r_bb));
    end
    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_hit <= n_hit;
            r_occ <= n_occ;
        end
    end

    assign o_out.valid    = r_v[NST];
    assign o_out.ray_hits = r_hit;
    assign o_out.occludes = r_occ;

    a_occ_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.occludes || o_out.ray_hits))
        else $error("occludes without hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST] && !o_out.ready) |=> (r_v[NST] && $stable(r_hit) && $stable(r_occ)))
        else $error("stalled result changed");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !o_out.ready) |-> !i_in.ready)
        else $error("request taken into full pipe");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !en[2]) |=> r_v[1])
        else $error("stalled stage lost request");

endmodule

// ===== verif/ray_sphere_occlusion_test_test.sv =====
`timescale 1ns / 1ps

module ray_sphere_occlusion_test_test;

    localparam int CW = rso_pkg::COORD_WIDTH_DEF;
    localparam int RW = rso_pkg::RADIUS_WIDTH;
    localparam int LIMIT = 2000000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord ex, ey, ez, tx, ty, tz, cx, cy, cz;
    } t_request;

    typedef struct packed {
        logic ray_hits;
        logic occludes;
    } t_verdict;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [RW-1:0] i_cfg_wdata = '0;

    rso_in_if #(.COORD_WIDTH(CW)) req_ch ();
    rso_out_if res_ch ();

    ray_sphere_occlusion_test #(.COORD_WIDTH(CW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    t_request   pending_reqs[$];
    t_verdict   expected_verdicts[$];
    logic [RW-1:0] radius_model;
    t_idle_mode idle_mode = IDLE_NONE;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;

    // exact occlusion test; 128-bit signed holds every intermediate here
    function automatic t_verdict predict_occlusion(t_request r, logic [RW-1:0] rad);
        logic signed [127:0] wx, wy, wz, vx, vy, vz, l2, p, q, d, a, b, rr;
        t_verdict res;
        wx = 128'(r.tx) - 128'(r.ex);
        wy = 128'(r.ty) - 128'(r.ey);
        wz = 128'(r.tz) - 128'(r.ez);
        vx = 128'(r.cx) - 128'(r.ex);
        vy = 128'(r.cy) - 128'(r.ey);
        vz = 128'(r.cz) - 128'(r.ez);
        rr = $signed({113'd0, rad});
        l2 = wx * wx + wy * wy + wz * wz;
        res = '0;
        if (l2 != 0) begin
            p = vx * wx + vy * wy + vz * wz;
            q = vx * vx + vy * vy + vz * vz - rr * rr;
            d = p * p - q * l2;
            res.ray_hits = (d >= 0);
            if (d >= 0) begin
                a = l2 - p;
                b = -l2 - p;
                res.occludes = (a > 0 && d < a * a) && (b < 0 || d > b * b);
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 &&
                !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
                  $urandom_range(99) < ((idle_mode == IDLE_SEND) ? 85 : 12))) begin
                t_request r;
                r = pending_reqs.pop_front();
                {req_ch.eye_x, req_ch.eye_y, req_ch.eye_z, req_ch.target_x,
                 req_ch.target_y, req_ch.target_z, req_ch.centre_x,
                 req_ch.centre_y, req_ch.centre_z} <= r;
                req_ch.valid <= 1'b1;
                expected_verdicts.insert(expected_verdicts.size(),
                                         predict_occlusion(r, radius_model));
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result with nothing expected");
                    err_count <= err_count + 1;
                end else begin
                    t_verdict e;
                    e = expected_verdicts.pop_front();
                    if (res_ch.ray_hits !== e.ray_hits) begin
                        $error("ray_hits expected %0d got %0d", e.ray_hits, res_ch.ray_hits);
                    end
                    if (res_ch.occludes !== e.occludes) begin
                        $error("occludes expected %0d got %0d", e.occludes, res_ch.occludes);
                    end
                    if (res_ch.ray_hits !== e.ray_hits || res_ch.occludes !== e.occludes) begin
                        err_count <= err_count + 1;
                    end
                end
            end
            res_ch.ready <= !((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                              $urandom_range(99) < ((idle_mode == IDLE_RECV) ? 85 : 12));
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return t_coord'($urandom_range(1) ? 32767 : -32768);
            1: return t_coord'($urandom_range(511) - 256);
            2: return t_coord'($urandom_range(4095) - 2048);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // random ray aimed near the sphere so hits and occlusions both show up
    function automatic t_request rand_request();
        t_request r;
        int span;
        r.ex = rand_coord();
        r.ey = rand_coord();
        r.ez = rand_coord();
        r.cx = rand_coord();
        r.cy = rand_coord();
        r.cz = rand_coord();
        if ($urandom_range(3) == 0) begin
            r.tx = rand_coord();
            r.ty = rand_coord();
            r.tz = rand_coord();
        end else begin
            span = 1 << $urandom_range(12, 4);
            r.tx = t_coord'(int'(r.ex) + (int'(r.cx) - int'(r.ex)) * 2 +
                            $signed($urandom_range(2 * span)) - span);
            r.ty = t_coord'(int'(r.ey) + (int'(r.cy) - int'(r.ey)) * 2 +
                            $signed($urandom_range(2 * span)) - span);
            r.tz = t_coord'(int'(r.ez) + (int'(r.cz) - int'(r.ez)) * 2 +
                            $signed($urandom_range(2 * span)) - span);
            if ($urandom_range(1)) begin
                r.tx = t_coord'((int'(r.ex) + int'(r.cx)) / 2);
                r.ty = t_coord'((int'(r.ey) + int'(r.cy)) / 2);
                r.tz = t_coord'((int'(r.ez) + int'(r.cz)) / 2);
            end
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_verdicts.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        radius_model = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_request(t_coord ex, t_coord ey, t_coord ez, t_coord tx,
                               t_coord ty, t_coord tz, t_coord cx, t_coord cy,
                               t_coord cz);
        t_request r;
        r = '{ex, ey, ez, tx, ty, tz, cx, cy, cz};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    initial begin
        logic [RW-1:0] radii[6];
        req_ch.valid = 1'b0;
        {req_ch.eye_x, req_ch.eye_y, req_ch.eye_z, req_ch.target_x, req_ch.target_y,
         req_ch.target_z, req_ch.centre_x, req_ch.centre_y, req_ch.centre_z} = '0;
        res_ch.ready = 1'b0;
        radius_model = rso_pkg::RADIUS_RESET;
        radii = '{15'd0, 15'h7fff, 15'd1, 15'd2048, 15'd300, 15'd64};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset radius of 1.0
        add_request(0, 0, 0, 0, 0, 0, 0, 0, 0);                 // eye on target
        add_request(100, -5, 7, 100, -5, 7, 0, 0, 0);           // eye on target, off origin
        add_request(0, 0, 0, 2560, 0, 0, 1280, 0, 0);           // sphere between: occludes
        add_request(0, 0, 0, 1280, 0, 0, 2560, 0, 0);           // sphere beyond target
        add_request(0, 0, 0, 2560, 0, 0, -1280, 0, 0);          // sphere behind eye
        add_request(0, 0, 0, 2560, 0, 0, 1280, 256, 0);         // tangent
        add_request(0, 0, 0, 2560, 0, 0, 1280, 257, 0);         // just misses
        add_request(0, 0, 0, 512, 0, 0, 0, 0, 0);              // eye inside sphere
        add_request(0, 0, 0, 256, 0, 0, 0, 0, 0);              // far crossing at target
        add_request(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
        add_request(32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, -32768);
        add_request(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767);
        add_request(-1, -1, -1, 0, 0, 0, -32768, -32768, -32768);
        add_request(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_radius((ph < 6) ? radii[ph] : RW'($urandom));
            idle_mode = t_idle_mode'(ph % 4);
            for (int k = 0; k < 170; k++) begin
                pending_reqs.insert(pending_reqs.size(), rand_request());
                // sender holds off until every result is back
                if (ph == 2 && k == 80) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
